### src/framed_dma_ring_sequencer_macros.svh
// Assertion macros shared by the frame ring sequencer modules.
`ifndef FRAMED_DMA_RING_SEQUENCER_MACROS_SVH
`define FRAMED_DMA_RING_SEQUENCER_MACROS_SVH

// Checks that a condition holds at every clock edge outside reset.
`define FDRS_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Checks that a consequence holds at the same edge as its cause.
`define FDRS_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

### src/fdrs_pkg.sv
// Types and constants shared by the frame ring sequencer files.
`timescale 1ns / 1ps

package fdrs_pkg;

    // Width of one channel field in the plan and period registers.
    localparam int CHAN_FIELD_BITS = 8;
    // Quotient bits resolved per cycle by the remainder unit.
    localparam int DIGIT_BITS = CHAN_FIELD_BITS;
    localparam int CFG_INDEX_BITS = 3;
    localparam int ADDR_BITS = 64;
    localparam int BYTES_BITS = 32;
    localparam int PLAN_BITS = 16;
    localparam int PROD_BITS = CHAN_FIELD_BITS + BYTES_BITS;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_READ_BASE   = 3'd0,
        CFG_WRITE_BASE  = 3'd1,
        CFG_READ_BYTES  = 3'd2,
        CFG_WRITE_BYTES = 3'd3,
        CFG_READ_PLAN   = 3'd4,
        CFG_WRITE_PLAN  = 3'd5,
        CFG_IRQ_PERIODS = 3'd6
    } cfg_index_t;

    typedef struct packed {
        logic start_read;
        logic start_write;
        logic ack_read_irq;
        logic ack_write_irq;
        logic read_engine_idle;
        logic write_engine_idle;
    } in_item_t;

    typedef struct packed {
        logic                  read_launch;
        logic [ADDR_BITS-1:0]  read_launch_address;
        logic [BYTES_BITS-1:0] read_launch_bytes;
        logic                  write_launch;
        logic [ADDR_BITS-1:0]  write_launch_address;
        logic [BYTES_BITS-1:0] write_launch_bytes;
        logic                  read_busy;
        logic                  write_busy;
        logic                  read_irq;
        logic                  write_irq;
    } out_item_t;

    // Request to the shared remainder unit.
    typedef struct packed {
        logic                       start;
        logic [CHAN_FIELD_BITS-1:0] divisor;
    } rem_req_t;

    // Response from the shared remainder unit.
    typedef struct packed {
        logic                       done;
        logic [CHAN_FIELD_BITS-1:0] rem;
    } rem_rsp_t;

endpackage

### src/fdrs_stream_if.sv
// Valid/ready stream channel carrying one item per handshake.
`timescale 1ns / 1ps

interface fdrs_stream_if #(
    parameter type item_t = logic
) ();

    logic  valid;
    logic  ready;
    item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);

endinterface

### src/fdrs_rem_unit.sv
// Iterative remainder unit: frame count modulo an 8-bit divisor, one digit per cycle.
`timescale 1ns / 1ps
`include "framed_dma_ring_sequencer_macros.svh"

module fdrs_rem_unit #(
    parameter int DIVIDEND_WIDTH = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  fdrs_pkg::rem_req_t              req,
    input  logic [DIVIDEND_WIDTH-1:0]       dividend,
    output fdrs_pkg::rem_rsp_t              rsp
);

    import fdrs_pkg::*;

    localparam int Steps = (DIVIDEND_WIDTH + DIGIT_BITS - 1) / DIGIT_BITS;
    localparam int PadWidth = Steps * DIGIT_BITS;
    localparam int CountWidth = $clog2(Steps + 1);

    logic [PadWidth-1:0]        shift_reg;
    logic [DIGIT_BITS-1:0]      rem_reg;
    logic [DIGIT_BITS-1:0]      div_reg;
    logic [CountWidth-1:0]      count_reg;
    logic                       done_reg;
    logic [DIGIT_BITS-1:0]      rem_next;
    logic [DIGIT_BITS:0]        trial;
    logic [DIGIT_BITS-1:0]      partial;

    // Restoring remainder over one digit of the dividend, most significant bit first.
    always_comb
    begin
        partial = rem_reg;
        trial = '0;
        for (int i = 0; i < DIGIT_BITS; i++)
        begin
            trial = {partial, shift_reg[PadWidth-1-i]};
            if (trial >= {1'b0, div_reg})
            begin
                trial = trial - {1'b0, div_reg};
            end
            partial = trial[DIGIT_BITS-1:0];
        end
        rem_next = partial;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_reg <= '0;
            rem_reg   <= '0;
            div_reg   <= '0;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                shift_reg <= PadWidth'(dividend);
                rem_reg   <= '0;
                div_reg   <= req.divisor;
                count_reg <= CountWidth'(Steps);
            end
            else if (count_reg != '0)
            begin
                shift_reg <= shift_reg << DIGIT_BITS;
                rem_reg   <= rem_next;
                count_reg <= count_reg - CountWidth'(1);
                done_reg  <= (count_reg == CountWidth'(1));
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.rem  = rem_reg;

    `FDRS_ASSERT_IMPLIES(a_rem_below_divisor, done_reg, rem_reg < div_reg, "remainder not below divisor")
    `FDRS_ASSERT_IMPLIES(a_no_restart_while_busy, req.start, count_reg == '0, "remainder unit restarted while busy")
    `FDRS_ASSERT_ALWAYS(a_count_in_range, count_reg <= CountWidth'(Steps), "remainder step count out of range")

endmodule

### src/framed_dma_ring_sequencer.sv
// Top level of the two-channel frame ring sequencer for a stream DMA.
`timescale 1ns / 1ps
`include "framed_dma_ring_sequencer_macros.svh"

// The sequencer takes one tick item at a time and answers each with one result item that
// reports the frame launched on the read and on the write channel, the launch address and
// length, and the busy and interrupt levels after the tick. A start bit is held pending
// until its channel is idle; starting latches the channel's base, frame length, plan and
// interrupt period, and launches frame 0 at the base. While running, an engine idle report
// counts one frame, may raise the interrupt, and either ends the run or launches the next
// frame at base + (done mod ring) * bytes. A tick in which neither channel counts a frame
// goes through the channel step of each channel and then the output step, which registers
// the result. Each channel that counts a frame adds a pass through the shared remainder
// unit for the interrupt period and, unless its run ends, a second pass for the ring slot,
// with the multiply by the frame length done as the ring pass ends, and then an address
// add step. The output step waits while an older result is still unread. A new item is
// accepted as soon as the sequencer is back in idle, even while the previous result is
// still waiting to be taken. Configuration writes belong to idle periods; a write to an
// index past the interrupt period register is dropped.
module framed_dma_ring_sequencer #(
    parameter int FRAME_COUNT_WIDTH = 32
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_write,
    input  logic [fdrs_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [fdrs_pkg::ADDR_BITS-1:0]        cfg_data,
    fdrs_stream_if.sink                           in_item,
    fdrs_stream_if.source                         out_item
);

    import fdrs_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHAN,
        ST_MOD_PERIOD,
        ST_MOD_RING,
        ST_ADDR,
        ST_OUT
    } state_t;

    localparam int FW = FRAME_COUNT_WIDTH;

    // Sequencer control.
    state_t                      state_reg;
    logic                        ch_reg;
    in_item_t                    item_reg;

    // Configuration registers, index 0 is the read channel.
    logic [ADDR_BITS-1:0]        base_cfg_reg [2];
    logic [BYTES_BITS-1:0]       bytes_cfg_reg [2];
    logic [PLAN_BITS-1:0]        plan_cfg_reg [2];
    logic [PLAN_BITS-1:0]        periods_cfg_reg;

    // Per-channel run state and the copies latched at start.
    logic                        active_reg [2];
    logic                        pending_reg [2];
    logic                        irq_reg [2];
    logic [FW-1:0]               done_reg [2];
    logic [ADDR_BITS-1:0]        base_lat_reg [2];
    logic [BYTES_BITS-1:0]       bytes_lat_reg [2];
    logic [CHAN_FIELD_BITS-1:0]  total_reg [2];
    logic [CHAN_FIELD_BITS-1:0]  ring_reg [2];
    logic [CHAN_FIELD_BITS-1:0]  period_reg [2];

    // Launch outcome of the current tick.
    logic                        launch_reg [2];
    logic [ADDR_BITS-1:0]        addr_reg [2];
    logic [BYTES_BITS-1:0]       len_reg [2];

    // Arithmetic path.
    logic [PROD_BITS-1:0]        prod_reg;
    rem_req_t                    rem_req_reg;
    logic [FW-1:0]               dividend_reg;
    rem_rsp_t                    rem_rsp;

    // Output register.
    logic                        out_valid_reg;
    out_item_t                   out_data_reg;

    // Per-channel views selected by the channel pointer.
    logic                        start_bit;
    logic                        ack_bit;
    logic                        idle_bit;
    logic                        irq_after_ack;
    logic                        pending_after_start;
    logic [FW-1:0]               done_inc;
    logic [CHAN_FIELD_BITS-1:0]  period_cfg_sel;
    logic                        run_ends;
    state_t                      after_chan_state;

    always_comb
    begin
        start_bit = ch_reg ? item_reg.start_write : item_reg.start_read;
        ack_bit   = ch_reg ? item_reg.ack_write_irq : item_reg.ack_read_irq;
        idle_bit  = ch_reg ? item_reg.write_engine_idle : item_reg.read_engine_idle;
        // Acknowledge clears first, so a new interrupt later in the tick still wins.
        irq_after_ack       = irq_reg[ch_reg] & ~ack_bit;
        pending_after_start = pending_reg[ch_reg] | start_bit;
        done_inc            = done_reg[ch_reg] + FW'(1);
        period_cfg_sel      = ch_reg ? periods_cfg_reg[PLAN_BITS-1:CHAN_FIELD_BITS]
                                     : periods_cfg_reg[CHAN_FIELD_BITS-1:0];
        // A total of zero means the run never ends.
        run_ends = (total_reg[ch_reg] != '0) && (done_reg[ch_reg] >= FW'(total_reg[ch_reg]));
        // The write channel is handled last; after it the result is built.
        after_chan_state = ch_reg ? ST_OUT : ST_CHAN;
    end

    fdrs_rem_unit #(
        .DIVIDEND_WIDTH (FW)
    ) u_rem (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (rem_req_reg),
        .dividend (dividend_reg),
        .rsp      (rem_rsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            ch_reg          <= 1'b0;
            item_reg        <= '0;
            periods_cfg_reg <= '0;
            prod_reg        <= '0;
            rem_req_reg     <= '0;
            dividend_reg    <= '0;
            out_valid_reg   <= 1'b0;
            out_data_reg    <= '0;
            for (int c = 0; c < 2; c++)
            begin
                base_cfg_reg[c]  <= '0;
                bytes_cfg_reg[c] <= '0;
                plan_cfg_reg[c]  <= '0;
                active_reg[c]    <= 1'b0;
                pending_reg[c]   <= 1'b0;
                irq_reg[c]       <= 1'b0;
                done_reg[c]      <= '0;
                base_lat_reg[c]  <= '0;
                bytes_lat_reg[c] <= '0;
                total_reg[c]     <= '0;
                ring_reg[c]      <= '0;
                period_reg[c]    <= '0;
                launch_reg[c]    <= 1'b0;
                addr_reg[c]      <= '0;
                len_reg[c]       <= '0;
            end
        end
        else
        begin
            rem_req_reg.start <= 1'b0;

            if (cfg_write)
            begin
                unique case (cfg_index)
                    CFG_READ_BASE:   base_cfg_reg[0]  <= cfg_data;
                    CFG_WRITE_BASE:  base_cfg_reg[1]  <= cfg_data;
                    CFG_READ_BYTES:  bytes_cfg_reg[0] <= cfg_data[BYTES_BITS-1:0];
                    CFG_WRITE_BYTES: bytes_cfg_reg[1] <= cfg_data[BYTES_BITS-1:0];
                    CFG_READ_PLAN:   plan_cfg_reg[0]  <= cfg_data[PLAN_BITS-1:0];
                    CFG_WRITE_PLAN:  plan_cfg_reg[1]  <= cfg_data[PLAN_BITS-1:0];
                    CFG_IRQ_PERIODS: periods_cfg_reg  <= cfg_data[PLAN_BITS-1:0];
                    default:         ;
                endcase
            end

            if (out_valid_reg && out_item.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_item.valid)
                    begin
                        item_reg  <= in_item.data;
                        ch_reg    <= 1'b0;
                        state_reg <= ST_CHAN;
                    end
                end

                ST_CHAN:
                begin
                    launch_reg[ch_reg] <= 1'b0;
                    addr_reg[ch_reg]   <= '0;
                    len_reg[ch_reg]    <= '0;
                    irq_reg[ch_reg]    <= irq_after_ack;
                    pending_reg[ch_reg] <= pending_after_start;
                    if (!active_reg[ch_reg])
                    begin
                        if (pending_after_start)
                        begin
                            // Start: latch the plan and launch frame 0 at the base.
                            pending_reg[ch_reg]   <= 1'b0;
                            active_reg[ch_reg]    <= 1'b1;
                            done_reg[ch_reg]      <= '0;
                            base_lat_reg[ch_reg]  <= base_cfg_reg[ch_reg];
                            bytes_lat_reg[ch_reg] <= bytes_cfg_reg[ch_reg];
                            total_reg[ch_reg]     <= plan_cfg_reg[ch_reg][CHAN_FIELD_BITS-1:0];
                            ring_reg[ch_reg]      <=
                                plan_cfg_reg[ch_reg][PLAN_BITS-1:CHAN_FIELD_BITS];
                            period_reg[ch_reg]    <= period_cfg_sel;
                            launch_reg[ch_reg]    <= 1'b1;
                            addr_reg[ch_reg]      <= base_cfg_reg[ch_reg];
                            len_reg[ch_reg]       <= bytes_cfg_reg[ch_reg];
                        end
                        ch_reg    <= 1'b1;
                        state_reg <= after_chan_state;
                    end
                    else if (idle_bit)
                    begin
                        // One frame finished; test it against the interrupt period.
                        done_reg[ch_reg]    <= done_inc;
                        dividend_reg        <= done_inc;
                        rem_req_reg.start   <= 1'b1;
                        rem_req_reg.divisor <= (period_reg[ch_reg] != '0) ?
                                               period_reg[ch_reg] : CHAN_FIELD_BITS'(1);
                        state_reg           <= ST_MOD_PERIOD;
                    end
                    else
                    begin
                        ch_reg    <= 1'b1;
                        state_reg <= after_chan_state;
                    end
                end

                ST_MOD_PERIOD:
                begin
                    if (rem_rsp.done)
                    begin
                        if ((period_reg[ch_reg] != '0) && (rem_rsp.rem == '0))
                        begin
                            irq_reg[ch_reg] <= 1'b1;
                        end
                        if (run_ends)
                        begin
                            active_reg[ch_reg] <= 1'b0;
                            ch_reg             <= 1'b1;
                            state_reg          <= after_chan_state;
                        end
                        else
                        begin
                            // Ring slot of the next frame; an empty ring acts as one frame.
                            dividend_reg        <= done_reg[ch_reg];
                            rem_req_reg.start   <= 1'b1;
                            rem_req_reg.divisor <= (ring_reg[ch_reg] != '0) ?
                                                   ring_reg[ch_reg] : CHAN_FIELD_BITS'(1);
                            state_reg           <= ST_MOD_RING;
                        end
                    end
                end

                ST_MOD_RING:
                begin
                    if (rem_rsp.done)
                    begin
                        prod_reg  <= PROD_BITS'(rem_rsp.rem) * PROD_BITS'(bytes_lat_reg[ch_reg]);
                        state_reg <= ST_ADDR;
                    end
                end

                ST_ADDR:
                begin
                    launch_reg[ch_reg] <= 1'b1;
                    addr_reg[ch_reg]   <= base_lat_reg[ch_reg] + ADDR_BITS'(prod_reg);
                    len_reg[ch_reg]    <= bytes_lat_reg[ch_reg];
                    ch_reg             <= 1'b1;
                    state_reg          <= after_chan_state;
                end

                ST_OUT:
                begin
                    // Wait only while an older result still sits unread.
                    if (!out_valid_reg || out_item.ready)
                    begin
                        out_valid_reg                     <= 1'b1;
                        out_data_reg.read_launch          <= launch_reg[0];
                        out_data_reg.read_launch_address  <= addr_reg[0];
                        out_data_reg.read_launch_bytes    <= len_reg[0];
                        out_data_reg.write_launch         <= launch_reg[1];
                        out_data_reg.write_launch_address <= addr_reg[1];
                        out_data_reg.write_launch_bytes   <= len_reg[1];
                        out_data_reg.read_busy            <= active_reg[0];
                        out_data_reg.write_busy           <= active_reg[1];
                        out_data_reg.read_irq             <= irq_reg[0];
                        out_data_reg.write_irq            <= irq_reg[1];
                        state_reg                         <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign in_item.ready  = (state_reg == ST_IDLE);
    assign out_item.valid = out_valid_reg;
    assign out_item.data  = out_data_reg;

    `FDRS_ASSERT_IMPLIES(a_launch_implies_busy, out_item.valid && (out_item.data.read_launch || out_item.data.write_launch), (!out_item.data.read_launch || out_item.data.read_busy) && (!out_item.data.write_launch || out_item.data.write_busy), "launch reported on a stopped channel")
    `FDRS_ASSERT_IMPLIES(a_read_done_below_total, (state_reg == ST_IDLE) && active_reg[0] && (total_reg[0] != '0), done_reg[0] < FW'(total_reg[0]), "read channel ran past its frame total")
    `FDRS_ASSERT_IMPLIES(a_write_done_below_total, (state_reg == ST_IDLE) && active_reg[1] && (total_reg[1] != '0), done_reg[1] < FW'(total_reg[1]), "write channel ran past its frame total")
    `FDRS_ASSERT_IMPLIES(a_rem_done_when_waiting, rem_rsp.done, (state_reg == ST_MOD_PERIOD) || (state_reg == ST_MOD_RING), "remainder result arrived with no waiting step")

endmodule

### tb/sv/framed_dma_ring_sequencer_tb.sv
// Self-checking testbench for the two-channel frame ring sequencer.
`timescale 1ns / 1ps

module framed_dma_ring_sequencer_tb;

    import fdrs_pkg::*;

    // Channel slots in the mirrored state, read fill first, write drain second.
    localparam int READ_CH = 0;
    localparam int WRITE_CH = 1;

    // The register file decodes three index bits but only seven are used, so the
    // last code is a write that the block must drop.
    localparam logic [CFG_INDEX_BITS-1:0] CFG_INDEX_UNUSED = 3'd7;

    // After the last result we let this many cycles pass before touching a register.
    localparam int SETTLE_CYCLES = 40;
    // Length of the receiver's long hold-off, which backs the block up.
    localparam int LONG_HOLD_CYCLES = 300;
    // Hard stop for a hung run, far past the slowest clean run.
    localparam int TIMEOUT_NS = 2_000_000;

    typedef enum bit {
        ROW_TICK,
        ROW_REGISTER
    } row_kind_t;

    // One line of the directed table: either a tick item or a register write.
    typedef struct {
        row_kind_t                 kind;
        in_item_t                  stim;
        bit                        typed;
        out_item_t                 want;
        logic [CFG_INDEX_BITS-1:0] index;
        logic [ADDR_BITS-1:0]      data;
    } directed_row_t;

    // What the testbench believes one channel holds. The base, length, plan and
    // period are the copies latched when the channel starts.
    typedef struct {
        bit                         active;
        bit                         pending;
        bit                         irq;
        bit [31:0]                  done;
        bit [ADDR_BITS-1:0]         base;
        bit [BYTES_BITS-1:0]        bytes;
        bit [CHAN_FIELD_BITS-1:0]   total;
        bit [CHAN_FIELD_BITS-1:0]   ring;
        bit [CHAN_FIELD_BITS-1:0]   period;
    } ring_channel_t;

    logic                       clk;
    logic                       rst_n;
    logic                       cfg_write;
    logic [CFG_INDEX_BITS-1:0]  cfg_index;
    logic [ADDR_BITS-1:0]       cfg_data;

    fdrs_stream_if #(.item_t(in_item_t))  tick_ch ();
    fdrs_stream_if #(.item_t(out_item_t)) report_ch ();

    framed_dma_ring_sequencer uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_item   (tick_ch),
        .out_item  (report_ch)
    );

    // Mirror of the register file and of both channels.
    bit [ADDR_BITS-1:0]   base_reg [2];
    bit [BYTES_BITS-1:0]  bytes_reg [2];
    bit [PLAN_BITS-1:0]   plan_reg [2];
    bit [PLAN_BITS-1:0]   period_reg;
    ring_channel_t        ring_chan [2];

    // Launch reports still owed by the block, oldest first.
    out_item_t            launch_reports_due [$];
    directed_row_t        directed_rows [$];
    out_item_t            report_want;
    int unsigned          mismatches = 0;
    // Set by the stimulus to ask the receiver for one long hold-off.
    bit                   hold_off_req = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("end of test: mismatches");
        $finish;
    end

    // Applies one register write to the mirror. Out-of-range indexes fall through.
    function automatic void mirror_register(input logic [CFG_INDEX_BITS-1:0] idx,
                                            input logic [ADDR_BITS-1:0] d);
        case (idx)
            CFG_READ_BASE:   base_reg[READ_CH] = d;
            CFG_WRITE_BASE:  base_reg[WRITE_CH] = d;
            CFG_READ_BYTES:  bytes_reg[READ_CH] = d[BYTES_BITS-1:0];
            CFG_WRITE_BYTES: bytes_reg[WRITE_CH] = d[BYTES_BITS-1:0];
            CFG_READ_PLAN:   plan_reg[READ_CH] = d[PLAN_BITS-1:0];
            CFG_WRITE_PLAN:  plan_reg[WRITE_CH] = d[PLAN_BITS-1:0];
            CFG_IRQ_PERIODS: period_reg = d[PLAN_BITS-1:0];
            default: ;
        endcase
    endfunction

    // Advances one channel by one tick and returns the frame it launches, if any.
    function automatic void advance_ring_channel(input int c, input bit start,
                                                 input bit ack, input bit idle,
                                                 output bit launch,
                                                 output bit [ADDR_BITS-1:0] addr,
                                                 output bit [BYTES_BITS-1:0] len);
        bit [31:0]          slots;
        bit [ADDR_BITS-1:0] slot;
        bit [ADDR_BITS-1:0] stride;
        launch = 1'b0;
        addr = '0;
        len = '0;
        // The acknowledge comes first, so an interrupt raised later in the same
        // tick survives it.
        if (ack)
            ring_chan[c].irq = 1'b0;
        if (start)
            ring_chan[c].pending = 1'b1;
        if (!ring_chan[c].active)
        begin
            // A pending start is taken only by a channel that is idle at the
            // beginning of the tick; an idle report on that tick is ignored.
            if (ring_chan[c].pending)
            begin
                ring_chan[c].pending = 1'b0;
                ring_chan[c].active = 1'b1;
                ring_chan[c].done = '0;
                ring_chan[c].base = base_reg[c];
                ring_chan[c].bytes = bytes_reg[c];
                ring_chan[c].total = plan_reg[c][CHAN_FIELD_BITS-1:0];
                ring_chan[c].ring = plan_reg[c][2*CHAN_FIELD_BITS-1:CHAN_FIELD_BITS];
                ring_chan[c].period = period_reg[c*CHAN_FIELD_BITS +: CHAN_FIELD_BITS];
                launch = 1'b1;
                addr = ring_chan[c].base;
                len = ring_chan[c].bytes;
            end
            return;
        end
        if (!idle)
            return;
        ring_chan[c].done = ring_chan[c].done + 32'd1;
        if (ring_chan[c].period != 0 && (ring_chan[c].done % ring_chan[c].period) == 0)
            ring_chan[c].irq = 1'b1;
        if (ring_chan[c].total != 0 && ring_chan[c].done >= ring_chan[c].total)
        begin
            ring_chan[c].active = 1'b0;
        end
        else
        begin
            // A ring length of zero behaves as a ring of one frame.
            slots = (ring_chan[c].ring == 0) ? 32'd1 : 32'(ring_chan[c].ring);
            slot = 64'(ring_chan[c].done % slots);
            stride = 64'(ring_chan[c].bytes);
            launch = 1'b1;
            addr = ring_chan[c].base + slot * stride;
            len = ring_chan[c].bytes;
        end
    endfunction

    // Works out the launch report that one tick item should produce.
    function automatic out_item_t sequence_tick(input in_item_t t);
        out_item_t               r;
        bit                      l;
        bit [ADDR_BITS-1:0]      a;
        bit [BYTES_BITS-1:0]     n;
        r = '0;
        advance_ring_channel(READ_CH, t.start_read, t.ack_read_irq, t.read_engine_idle,
                             l, a, n);
        r.read_launch = l;
        r.read_launch_address = a;
        r.read_launch_bytes = n;
        advance_ring_channel(WRITE_CH, t.start_write, t.ack_write_irq, t.write_engine_idle,
                             l, a, n);
        r.write_launch = l;
        r.write_launch_address = a;
        r.write_launch_bytes = n;
        r.read_busy = ring_chan[READ_CH].active;
        r.write_busy = ring_chan[WRITE_CH].active;
        r.read_irq = ring_chan[READ_CH].irq;
        r.write_irq = ring_chan[WRITE_CH].irq;
        return r;
    endfunction

    function automatic directed_row_t tick_row(input in_item_t t);
        directed_row_t row;
        row.kind = ROW_TICK;
        row.stim = t;
        row.typed = 1'b0;
        row.want = '0;
        row.index = '0;
        row.data = '0;
        return row;
    endfunction

    function automatic directed_row_t register_row(input logic [CFG_INDEX_BITS-1:0] idx,
                                                   input logic [ADDR_BITS-1:0] d);
        directed_row_t row;
        row = tick_row('0);
        row.kind = ROW_REGISTER;
        row.index = idx;
        row.data = d;
        return row;
    endfunction

    // Appends one line to the end of the directed table.
    function automatic void add_row(input directed_row_t r);
        directed_rows = {directed_rows, r};
    endfunction

    // Random tick: starts are rare, acknowledges common, and engine idle reports
    // come with a weight out of 16 so that runs advance at a chosen pace.
    function automatic in_item_t random_tick(input int unsigned idle_weight,
                                             input bit force_start);
        in_item_t t;
        t.start_read = force_start || ($urandom_range(0, 15) == 0);
        t.start_write = force_start || ($urandom_range(0, 15) == 0);
        t.ack_read_irq = ($urandom_range(0, 3) == 0);
        t.ack_write_irq = ($urandom_range(0, 3) == 0);
        t.read_engine_idle = ($urandom_range(0, 15) < idle_weight);
        t.write_engine_idle = ($urandom_range(0, 15) < idle_weight);
        return t;
    endfunction

    function automatic logic [ADDR_BITS-1:0] random_base();
        case ($urandom_range(0, 3))
            0: return '0;
            1: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [ADDR_BITS-1:0] random_frame_bytes();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return 64'h0000_0000_FFFF_FFFF;
            2: return 64'($urandom);
            default: return 64'($urandom_range(1, 4096));
        endcase
    endfunction

    // A short plan: ring of up to five frames (sometimes the full 255) and a run
    // of one to ten frames, so that runs end and restart often.
    function automatic logic [ADDR_BITS-1:0] random_short_plan();
        bit [CHAN_FIELD_BITS-1:0] ring;
        bit [CHAN_FIELD_BITS-1:0] total;
        ring = ($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom_range(0, 5));
        total = 8'($urandom_range(1, 10));
        return {48'd0, ring, total};
    endfunction

    // Each register write raises the write enable for its edge and lowers it again before the
    // next write, so the write enable never gets two assignments in the same time step.
    task automatic program_register(input logic [CFG_INDEX_BITS-1:0] idx,
                                    input logic [ADDR_BITS-1:0] d);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= d;
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
        mirror_register(idx, d);
    endtask

    // Offers one tick item and holds it until the block takes it. The expected
    // report is queued at the acceptance edge, so the queue stays in item order.
    task automatic offer_tick(input in_item_t t, input bit typed, input out_item_t want);
        out_item_t predicted;
        tick_ch.valid <= 1'b1;
        tick_ch.data <= t;
        @(posedge clk);
        while (tick_ch.ready !== 1'b1)
            @(posedge clk);
        predicted = sequence_tick(t);
        launch_reports_due = {launch_reports_due, (typed ? want : predicted)};
    endtask

    // Stops offering and waits until every owed report has come back, then lets
    // the block settle so that a register write finds it idle.
    task automatic drain_results();
        tick_ch.valid <= 1'b0;
        while (launch_reports_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Writes a full register set for one phase of the random part. The extreme set drives the
    // read ring at the top of every range and the write ring at zero base and length but top
    // plan and period; the endless set lets both channels run without end.
    task automatic program_phase(input bit extreme, input bit endless);
        bit [CHAN_FIELD_BITS-1:0] read_period;
        bit [CHAN_FIELD_BITS-1:0] write_period;
        read_period = 8'($urandom_range(0, 4));
        write_period = 8'($urandom_range(0, 4));
        if ($urandom_range(0, 2) == 0)
            program_register(CFG_INDEX_UNUSED, {$urandom, $urandom});
        if (extreme)
        begin
            program_register(CFG_READ_BASE, '1);
            program_register(CFG_WRITE_BASE, '0);
            program_register(CFG_READ_BYTES, 64'h0000_0000_FFFF_FFFF);
            program_register(CFG_WRITE_BYTES, '0);
            program_register(CFG_READ_PLAN, 64'h0000_0000_0000_FFFF);
            program_register(CFG_WRITE_PLAN, 64'h0000_0000_0000_FFFF);
            program_register(CFG_IRQ_PERIODS, 64'h0000_0000_0000_FFFF);
        end
        else
        begin
            program_register(CFG_READ_BASE, random_base());
            program_register(CFG_WRITE_BASE, random_base());
            program_register(CFG_READ_BYTES, random_frame_bytes());
            program_register(CFG_WRITE_BYTES, random_frame_bytes());
            if (endless)
            begin
                // A frame total of zero means the channel never stops, so this
                // setting is kept for the last phase of the run.
                program_register(CFG_READ_PLAN, {56'd0, 8'($urandom_range(0, 4))} << 8);
                program_register(CFG_WRITE_PLAN, {56'd0, 8'($urandom_range(0, 4))} << 8);
            end
            else
            begin
                program_register(CFG_READ_PLAN, random_short_plan());
                program_register(CFG_WRITE_PLAN, random_short_plan());
            end
            program_register(CFG_IRQ_PERIODS, {48'd0, write_period, read_period});
        end
    endtask

    // One phase of the random part: reprogram while idle, then offer ticks in
    // bursts with random gaps, now and then pausing until the block is empty.
    task automatic run_phase(input bit extreme, input bit endless,
                             input int unsigned ticks, input bit long_hold);
        int unsigned idle_weight;
        int unsigned burst_left;
        int unsigned gap;
        int unsigned k;
        drain_results();
        program_phase(extreme, endless);
        idle_weight = extreme ? 15 : $urandom_range(3, 10);
        burst_left = $urandom_range(1, 16);
        if (long_hold)
            hold_off_req = 1'b1;
        for (k = 0; k < ticks; k++)
        begin
            // Both starts are raised on the first tick so that every phase runs
            // its new plan, even when a channel is still busy with the old one.
            offer_tick(random_tick(idle_weight, k == 0), 1'b0, '0);
            if (k + 1 < ticks)
            begin
                if ($urandom_range(0, 49) == 0)
                begin
                    drain_results();
                end
                else if (burst_left == 0)
                begin
                    gap = $urandom_range(0, 6);
                    if (gap != 0)
                    begin
                        tick_ch.valid <= 1'b0;
                        repeat (gap) @(posedge clk);
                    end
                    // Now and then a long burst with no gaps at all.
                    burst_left = ($urandom_range(0, 4) == 0) ? 40 : $urandom_range(1, 16);
                end
                else
                begin
                    burst_left--;
                end
            end
        end
    endtask

    // The receiver switches among stall patterns, from always ready down to ready with a
    // chance of one in four, and takes one long hold-off on request.
    initial
    begin : receiver
        int unsigned cycle_count;
        int unsigned hold_left;
        int unsigned pattern;
        cycle_count = 0;
        hold_left = 0;
        pattern = 0;
        report_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (hold_off_req && hold_left == 0)
            begin
                hold_off_req = 1'b0;
                hold_left = LONG_HOLD_CYCLES;
            end
            if (cycle_count % 50 == 0)
                pattern = $urandom_range(0, 3);
            if (hold_left != 0)
            begin
                hold_left--;
                report_ch.ready <= 1'b0;
            end
            else
            begin
                case (pattern)
                    0: report_ch.ready <= 1'b1;
                    1: report_ch.ready <= ($urandom_range(0, 3) != 0);
                    2: report_ch.ready <= ($urandom_range(0, 1) != 0);
                    default: report_ch.ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    task automatic check_field(input string name, input logic [ADDR_BITS-1:0] exp,
                               input logic [ADDR_BITS-1:0] act);
        if (exp !== act)
        begin
            $display("%0t: %s expected %h actual %h", $time, name, exp, act);
            mismatches++;
        end
    endtask

    // Every accepted report is compared, field by field, with the oldest one owed.
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && report_ch.valid === 1'b1 && report_ch.ready === 1'b1)
        begin
            if (launch_reports_due.size() == 0)
            begin
                $display("%0t: report expected none actual %h", $time, report_ch.data);
                mismatches++;
            end
            else
            begin
                report_want = launch_reports_due.pop_front();
                check_field("read_launch", 64'(report_want.read_launch),
                            64'(report_ch.data.read_launch));
                check_field("read_launch_address", report_want.read_launch_address,
                            report_ch.data.read_launch_address);
                check_field("read_launch_bytes", 64'(report_want.read_launch_bytes),
                            64'(report_ch.data.read_launch_bytes));
                check_field("write_launch", 64'(report_want.write_launch),
                            64'(report_ch.data.write_launch));
                check_field("write_launch_address", report_want.write_launch_address,
                            report_ch.data.write_launch_address);
                check_field("write_launch_bytes", 64'(report_want.write_launch_bytes),
                            64'(report_ch.data.write_launch_bytes));
                check_field("read_busy", 64'(report_want.read_busy),
                            64'(report_ch.data.read_busy));
                check_field("write_busy", 64'(report_want.write_busy),
                            64'(report_ch.data.write_busy));
                check_field("read_irq", 64'(report_want.read_irq),
                            64'(report_ch.data.read_irq));
                check_field("write_irq", 64'(report_want.write_irq),
                            64'(report_ch.data.write_irq));
            end
        end
    end

    initial
    begin : stimulus
        out_item_t     both_started;
        directed_row_t row;
        bit            after_tick;
        int unsigned   phase;

        rst_n <= 1'b0;
        cfg_write <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        tick_ch.valid <= 1'b0;
        tick_ch.data <= '0;

        // The mirror starts from the reset state: every register and every
        // channel field is zero.
        for (int c = 0; c < 2; c++)
        begin
            base_reg[c] = '0;
            bytes_reg[c] = '0;
            plan_reg[c] = '0;
            ring_chan[c] = '{default: '0};
        end
        period_reg = '0;

        // Report of the first start: both frames launch at their bases with the
        // full-width read length, both channels busy, no interrupt yet.
        both_started = '0;
        both_started.read_launch = 1'b1;
        both_started.read_launch_address = 64'hFFFF_FFFF_FFFF_FF00;
        both_started.read_launch_bytes = 32'hFFFF_FFFF;
        both_started.write_launch = 1'b1;
        both_started.write_launch_address = 64'h0000_0000_8000_0000;
        both_started.write_launch_bytes = 32'h0000_0100;
        both_started.read_busy = 1'b1;
        both_started.write_busy = 1'b1;

        // Directed table. Tick bits, left to right: start_read, start_write,
        // ack_read_irq, ack_write_irq, read_engine_idle, write_engine_idle.
        // Acks and idle reports on an idle block: nothing moves, report all zero.
        row = tick_row(6'b001111);
        row.typed = 1'b1;
        add_row(row);
        // A write past the last register must be dropped.
        add_row(register_row(CFG_INDEX_UNUSED, '1));
        // Read ring near the top of memory with the largest frame, so the second
        // frame address wraps past 2^64.
        add_row(register_row(CFG_READ_BASE, 64'hFFFF_FFFF_FFFF_FF00));
        add_row(register_row(CFG_READ_BYTES, 64'h0000_0000_FFFF_FFFF));
        add_row(register_row(CFG_READ_PLAN, 64'h0304));
        add_row(register_row(CFG_WRITE_BASE, 64'h0000_0000_8000_0000));
        add_row(register_row(CFG_WRITE_BYTES, 64'h0100));
        // Ring length zero on the write side: every frame at the base.
        add_row(register_row(CFG_WRITE_PLAN, 64'h0003));
        add_row(register_row(CFG_IRQ_PERIODS, 64'h0201));
        // Both start; the idle reports on the start tick are ignored.
        row = tick_row(6'b110011);
        row.typed = 1'b1;
        row.want = both_started;
        add_row(row);
        // The plan changes under a running read channel and must not take effect.
        add_row(register_row(CFG_READ_PLAN, 64'h0101));
        // A start while running stays pending.
        add_row(tick_row(6'b100010));
        // Acknowledge and a new read interrupt in the same tick: the flag stays set.
        add_row(tick_row(6'b001011));
        add_row(tick_row(6'b000011));
        // Both runs reach their totals and stop.
        add_row(tick_row(6'b000011));
        // The pending read start is taken with the newer plan.
        add_row(tick_row(6'b000000));
        add_row(tick_row(6'b001110));
        add_row(tick_row(6'b001100));
        add_row(tick_row(6'b000000));

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the table back to back, draining before any register write that
        // follows a tick.
        after_tick = 1'b0;
        foreach (directed_rows[i])
        begin
            row = directed_rows[i];
            if (row.kind == ROW_REGISTER)
            begin
                if (after_tick)
                    drain_results();
                program_register(row.index, row.data);
                after_tick = 1'b0;
            end
            else
            begin
                offer_tick(row.stim, row.typed, row.want);
                after_tick = 1'b1;
            end
        end

        // Random part: seven short phases, one long phase that runs both rings
        // to 255 frames at the extremes, and a last phase with endless runs.
        for (phase = 0; phase < 7; phase++)
            run_phase(1'b0, 1'b0, 30, phase == 1 || phase == 4);
        run_phase(1'b1, 1'b0, 300, 1'b0);
        run_phase(1'b0, 1'b1, 30, 1'b0);

        drain_results();
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
